FILE: design/dmwbc_pkg.sv
// Shared types and constants for the direct-mapped write-back cache.
// No dependencies; imported by the register block and the top level.
`timescale 1ns / 1ps

package dmwbc_pkg;

   localparam int WORD_BYTES = 4;
   localparam int WORD_BITS  = 8 * WORD_BYTES;
   localparam int LAT_W      = 16;
   localparam int CSR_IDX_W  = 2;

   // register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_MEM_RD_LAT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEM_WR_LAT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CACHE_RD_LAT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CACHE_WR_LAT = 2'd3;

   localparam logic [LAT_W-1:0] MEM_RD_LAT_RST   = 16'd100;
   localparam logic [LAT_W-1:0] MEM_WR_LAT_RST   = 16'd50;
   localparam logic [LAT_W-1:0] CACHE_RD_LAT_RST = 16'd1;
   localparam logic [LAT_W-1:0] CACHE_WR_LAT_RST = 16'd1;

   typedef struct packed {
      logic [LAT_W-1:0] mem_rd;
      logic [LAT_W-1:0] mem_wr;
      logic [LAT_W-1:0] cache_rd;
      logic [LAT_W-1:0] cache_wr;
   } lat_type;

endpackage

FILE: design/dmwbc_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module dmwbc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/dmwbc_csr.sv
// Latency configuration registers of the cache.
// Depends on dmwbc_pkg for the register indexes and the latency struct.
`timescale 1ns / 1ps

module dmwbc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [dmwbc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dmwbc_pkg::LAT_W-1:0]        csr_write_data,
   output dmwbc_pkg::lat_type                 lat
);
   import dmwbc_pkg::*;

   lat_type lat_ff;
   lat_type lat_in;

   always_comb begin
      lat_in = lat_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MEM_RD_LAT:   lat_in.mem_rd   = csr_write_data;
            CSR_MEM_WR_LAT:   lat_in.mem_wr   = csr_write_data;
            CSR_CACHE_RD_LAT: lat_in.cache_rd = csr_write_data;
            CSR_CACHE_WR_LAT: lat_in.cache_wr = csr_write_data;
            default:          lat_in = lat_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lat_ff.mem_rd   <= MEM_RD_LAT_RST;
         lat_ff.mem_wr   <= MEM_WR_LAT_RST;
         lat_ff.cache_rd <= CACHE_RD_LAT_RST;
         lat_ff.cache_wr <= CACHE_WR_LAT_RST;
      end else begin
         lat_ff <= lat_in;
      end
   end

   assign csr_ready = 1'b1;
   assign lat       = lat_ff;

endmodule

FILE: design/direct_mapped_write_back_cache_top.sv
// Top level of the direct-mapped write-back write-allocate cache: sequencer,
// line/backing RAM instances, time accumulator and output register.
// Depends on dmwbc_pkg, dmwbc_ram and dmwbc_csr.
// Each item passes through the line RAM read, the read-modify-write step and
// the time accumulation step, which loads its result into the output register;
// an address error item skips the read-modify-write step. The accumulation
// step holds while the output register is full; a new item is taken only once
// the result is loaded. After reset a clearing pass zeroes both RAMs;
// req_ready stays low during it while configuration writes are still taken.
`timescale 1ns / 1ps

module direct_mapped_write_back_cache_top #(
   parameter int CACHE_BYTES  = 2048,   // power of two
   parameter int BLOCK_BYTES  = 8,      // 4 or 8
   parameter int MEMORY_BYTES = 65536   // power of two
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_op,
   input  logic [31:0]                      req_address,
   input  logic [31:0]                      req_write_data,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [31:0]                      rsp_read_data,
   output logic                             rsp_hit,
   output logic                             rsp_wrote_back,
   output logic                             rsp_address_error,
   output logic [31:0]                      rsp_total_time,
   // configuration channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dmwbc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dmwbc_pkg::LAT_W-1:0]      csr_write_data
);
   import dmwbc_pkg::*;

   localparam int LINES      = CACHE_BYTES / BLOCK_BYTES;
   localparam int MEM_BLOCKS = MEMORY_BYTES / BLOCK_BYTES;
   localparam int WORDS      = BLOCK_BYTES / WORD_BYTES;
   localparam int BLK_W      = 8 * BLOCK_BYTES;
   localparam int BO         = $clog2(BLOCK_BYTES);
   localparam int CO         = $clog2(CACHE_BYTES);
   localparam int IDX_W      = $clog2(LINES);
   localparam int MEM_AW     = $clog2(MEM_BLOCKS);
   localparam int TAG_SPAN   = (MEMORY_BYTES > CACHE_BYTES) ? MEMORY_BYTES / CACHE_BYTES : 1;
   localparam int TAG_W      = (TAG_SPAN > 1) ? $clog2(TAG_SPAN) : 1;
   localparam int WSEL_W     = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int LINE_W     = 2 + TAG_W + BLK_W;
   localparam int CLR_DEPTH  = (LINES > MEM_BLOCKS) ? LINES : MEM_BLOCKS;
   localparam int CLR_W      = $clog2(CLR_DEPTH);
   localparam int INC_W      = LAT_W + 2;
   localparam logic [31:0]      MemLimit = 32'(MEMORY_BYTES);
   localparam logic [CLR_W-1:0] ClrLast  = CLR_W'(CLR_DEPTH - 1);

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_LOOKUP = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   lat_type lat;

   // control registers
   state_type        state_ff, state_in;
   logic [CLR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [31:0]      time_ff, time_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // captured item and lookup results (payload, no reset)
   logic              op_ff, op_in;
   logic              err_ff, err_in;
   logic [31:0]       wdata_ff, wdata_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic [WSEL_W-1:0] wsel_ff, wsel_in;
   logic              hit_ff, hit_in;
   logic              wb_ff, wb_in;
   logic [31:0]       rdata_ff, rdata_in;

   // output register payload
   logic [31:0] rsp_rdata_ff, rsp_rdata_in;
   logic        rsp_hit_ff, rsp_hit_in;
   logic        rsp_wb_ff, rsp_wb_in;
   logic        rsp_err_ff, rsp_err_in;
   logic [31:0] rsp_time_ff, rsp_time_in;

   // RAM ports
   logic              line_we, mem_we, ram_re;
   logic [IDX_W-1:0]  line_waddr;
   logic [MEM_AW-1:0] mem_waddr;
   logic [LINE_W-1:0] line_wdata, line_rdata;
   logic [BLK_W-1:0]  mem_wdata, mem_rdata;

   // lookup datapath
   logic               req_acc, addr_err, out_free, clearing, lookup;
   logic               line_valid, line_dirty, hit_c, wb_c, new_dirty;
   logic [TAG_W-1:0]   line_tag;
   logic [BLK_W-1:0]   line_block, base_block, merged_block, new_block;
   logic [31:0]        word_c;
   logic [TAG_W+IDX_W-1:0] victim_blk;
   logic [INC_W-1:0]   inc;

   dmwbc_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .lat            (lat)
   );

   // line store: {valid, dirty, tag, block}
   dmwbc_ram #(.WIDTH(LINE_W), .DEPTH(LINES)) u_line_ram (
      .clock   (clock),
      .wr_en   (line_we),
      .wr_addr (line_waddr),
      .wr_data (line_wdata),
      .rd_en   (ram_re),
      .rd_addr (req_address[BO +: IDX_W]),
      .rd_data (line_rdata)
   );

   // backing memory, one block per entry
   dmwbc_ram #(.WIDTH(BLK_W), .DEPTH(MEM_BLOCKS)) u_mem_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (ram_re),
      .rd_addr (req_address[BO +: MEM_AW]),
      .rd_data (mem_rdata)
   );

   assign clearing  = (state_ff == ST_CLEAR);
   assign lookup    = (state_ff == ST_LOOKUP);
   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign addr_err  = (req_address >= MemLimit);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   // The fill block is read speculatively with the line; a miss always
   // evicts a block with another tag, so the read never sees the write-back.
   assign ram_re    = req_acc;

   // Decode the line read in the lookup cycle.
   assign line_valid = line_rdata[LINE_W-1];
   assign line_dirty = line_rdata[LINE_W-2];
   assign line_tag   = line_rdata[BLK_W +: TAG_W];
   assign line_block = line_rdata[BLK_W-1:0];
   assign hit_c      = line_valid && (line_tag == tag_ff);
   assign wb_c       = !hit_c && line_valid && line_dirty;
   assign base_block = hit_c ? line_block : mem_rdata;
   assign new_dirty  = op_ff || (hit_c && line_dirty);
   assign victim_blk = {line_tag, idx_ff};

   // Pick the addressed word and merge write data into the line.
   always_comb begin
      word_c       = '0;
      merged_block = base_block;
      for (int w = 0; w < WORDS; w++) begin
         if (wsel_ff == WSEL_W'(w)) begin
            word_c = base_block[w*WORD_BITS +: WORD_BITS];
            merged_block[w*WORD_BITS +: WORD_BITS] = wdata_ff;
         end
      end
   end

   assign new_block = op_ff ? merged_block : base_block;

   // Zero both RAMs during the clearing pass; otherwise write back the line
   // and, on a dirty miss, the victim block.
   assign line_we    = clearing || lookup;
   assign line_waddr = clearing ? clr_cnt_ff[IDX_W-1:0] : idx_ff;
   assign line_wdata = clearing ? '0 : {1'b1, new_dirty, tag_ff, new_block};
   assign mem_we     = clearing || (lookup && wb_c);
   assign mem_waddr  = clearing ? clr_cnt_ff[MEM_AW-1:0] : victim_blk[MEM_AW-1:0];
   assign mem_wdata  = clearing ? '0 : line_block;

   // Time added by this item.
   always_comb begin
      inc = '0;
      if (!err_ff) begin
         inc = (hit_ff ? INC_W'(0) : INC_W'(lat.mem_rd))
             + (wb_ff ? INC_W'(lat.mem_wr) : INC_W'(0))
             + (op_ff ? INC_W'(lat.cache_wr) : INC_W'(lat.cache_rd));
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      time_in      = time_ff;
      rsp_valid_in = rsp_valid_ff;
      op_in        = op_ff;
      err_in       = err_ff;
      wdata_in     = wdata_ff;
      idx_in       = idx_ff;
      tag_in       = tag_ff;
      wsel_in      = wsel_ff;
      hit_in       = hit_ff;
      wb_in        = wb_ff;
      rdata_in     = rdata_ff;
      rsp_rdata_in = rsp_rdata_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_wb_in    = rsp_wb_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_time_in  = rsp_time_ff;

      // drop the result once it is taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ClrLast) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               op_in    = req_op;
               err_in   = addr_err;
               wdata_in = req_write_data;
               idx_in   = req_address[BO +: IDX_W];
               tag_in   = req_address[CO +: TAG_W];
               wsel_in  = WSEL_W'(req_address[BO-1:0] >> 2);
               hit_in   = 1'b0;
               wb_in    = 1'b0;
               rdata_in = '0;
               // an out-of-range item touches no state: skip the lookup
               state_in = addr_err ? ST_FINISH : ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            hit_in   = hit_c;
            wb_in    = wb_c;
            rdata_in = op_ff ? 32'd0 : word_c;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output register can take the result
            if (out_free) begin
               time_in      = time_ff + 32'(inc);
               rsp_valid_in = 1'b1;
               rsp_rdata_in = rdata_ff;
               rsp_hit_in   = hit_ff;
               rsp_wb_in    = wb_ff;
               rsp_err_in   = err_ff;
               rsp_time_in  = time_ff + 32'(inc);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         time_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      err_ff       <= err_in;
      wdata_ff     <= wdata_in;
      idx_ff       <= idx_in;
      tag_ff       <= tag_in;
      wsel_ff      <= wsel_in;
      hit_ff       <= hit_in;
      wb_ff        <= wb_in;
      rdata_ff     <= rdata_in;
      rsp_rdata_ff <= rsp_rdata_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_wb_ff    <= rsp_wb_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_time_ff  <= rsp_time_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rsp_rdata_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_wrote_back    = rsp_wb_ff;
   assign rsp_address_error = rsp_err_ff;
   assign rsp_total_time    = rsp_time_ff;

   // backing memory is written only by the clearing pass or a write-back
   a_mem_write_source: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (clearing || (lookup && !hit_c)))
      else $error("backing memory written outside clear or write-back");

   a_lookup_after_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOKUP) |-> $past(req_valid && req_ready && !addr_err))
      else $error("lookup without an accepted in-range item");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_address_error) |-> (!rsp_hit && !rsp_wrote_back && rsp_read_data == 32'd0))
      else $error("address error result carries access flags");

   a_hit_no_wb: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> !rsp_wrote_back)
      else $error("hit reported together with a write-back");

endmodule

FILE: test/direct_mapped_write_back_cache_top_tb.sv
`timescale 1ns / 1ps
// Testbench for direct_mapped_write_back_cache_top: issues random and directed word reads
// and writes, keeps its own copy of lines, backing memory and time total, checks each response.
// Depends on dmwbc_pkg and the cache RTL only.

module direct_mapped_write_back_cache_top_tb;
   import dmwbc_pkg::*;

   localparam int CACHE_BYTES  = 2048;
   localparam int BLOCK_BYTES  = 8;
   localparam int MEMORY_BYTES = 65536;
   localparam int NUM_LINES    = CACHE_BYTES / BLOCK_BYTES;
   localparam int MEM_BLOCKS   = MEMORY_BYTES / BLOCK_BYTES;
   localparam int TAG_COUNT    = MEMORY_BYTES / CACHE_BYTES;
   localparam logic [LAT_W-1:0] LAT_MAX = '1;
   localparam int DRAIN_LIMIT  = 2000;   // cycles allowed to empty the response queue

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef struct packed {
      logic [31:0] read_data;
      logic        hit;
      logic        wrote_back;
      logic        address_error;
      logic [31:0] total_time;
   } access_outcome_type;

   // all block inputs start at known values
   logic                 clock;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_ready;
   logic                 req_op         = OP_READ;
   logic [31:0]          req_address    = '0;
   logic [31:0]          req_write_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready      = 1'b0;
   logic [31:0]          rsp_read_data;
   logic                 rsp_hit;
   logic                 rsp_wrote_back;
   logic                 rsp_address_error;
   logic [31:0]          rsp_total_time;
   logic                 csr_valid      = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index      = CSR_MEM_RD_LAT;
   logic [LAT_W-1:0]     csr_write_data = '0;

   // mirror of the cache, its backing memory and the time total
   bit          line_live  [NUM_LINES];
   bit          line_mod   [NUM_LINES];
   bit [20:0]   line_owner [NUM_LINES];
   bit [63:0]   line_bytes [NUM_LINES];
   bit [63:0]   dram       [MEM_BLOCKS];
   bit [31:0]   elapsed    = '0;
   lat_type     lat        = '{MEM_RD_LAT_RST, MEM_WR_LAT_RST, CACHE_RD_LAT_RST,
                               CACHE_WR_LAT_RST};

   access_outcome_type access_outcomes [$];
   int                 mismatches = 0;

   // idle bursts on both channels while set; the address window of random traffic
   bit          bursts_on  = 1'b1;
   int unsigned tag_base   = 0;
   int unsigned tag_span   = 4;
   int unsigned index_base = 0;
   int unsigned index_span = 8;

   direct_mapped_write_back_cache_top #(
      .CACHE_BYTES  (CACHE_BYTES),
      .BLOCK_BYTES  (BLOCK_BYTES),
      .MEMORY_BYTES (MEMORY_BYTES)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_address       (req_address),
      .req_write_data    (req_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_read_data     (rsp_read_data),
      .rsp_hit           (rsp_hit),
      .rsp_wrote_back    (rsp_wrote_back),
      .rsp_address_error (rsp_address_error),
      .rsp_total_time    (rsp_total_time),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop: far beyond the slowest correct run (clearing pass plus every item
   // meeting the longest gap and the longest stall).
   initial begin
      #2_000_000;
      $display("direct_mapped_write_back_cache_top: mismatch");
      $finish;
   end

   // Apply one accepted access to the mirror and return the response it must produce.
   function automatic access_outcome_type apply_access(input logic op,
                                                       input logic [31:0] addr,
                                                       input logic [31:0] wdata);
      access_outcome_type r;
      int unsigned        tg, idx, sel, blk, victim;
      bit [63:0]          fill;
      r = '0;
      // out of range: flag it, touch nothing, report the unchanged total
      if (addr >= MEMORY_BYTES) begin
         r.address_error = 1'b1;
         r.total_time    = elapsed;
         return r;
      end
      tg  = addr / CACHE_BYTES;
      idx = (addr / BLOCK_BYTES) % NUM_LINES;
      sel = (addr % BLOCK_BYTES) / WORD_BYTES;
      blk = addr / BLOCK_BYTES;
      r.hit = line_live[idx] && line_owner[idx] == tg;
      if (!r.hit) begin
         fill = dram[blk % MEM_BLOCKS];
         elapsed += lat.mem_rd;
         // evict a dirty victim to tag * cache size + index * block size
         if (line_live[idx] && line_mod[idx]) begin
            victim = line_owner[idx] * NUM_LINES + idx;
            if (victim < MEM_BLOCKS)
               dram[victim] = line_bytes[idx];
            elapsed += lat.mem_wr;
            r.wrote_back = 1'b1;
         end
         line_bytes[idx] = fill;
         line_live[idx]  = 1'b1;
         line_owner[idx] = tg;
         line_mod[idx]   = 1'b0;
      end
      if (op == OP_READ) begin
         r.read_data = line_bytes[idx][sel*WORD_BITS +: WORD_BITS];
         elapsed += lat.cache_rd;
      end else begin
         line_bytes[idx][sel*WORD_BITS +: WORD_BITS] = wdata;
         line_mod[idx] = 1'b1;
         elapsed += lat.cache_wr;
      end
      r.total_time = elapsed;
      return r;
   endfunction

   // Mostly in-range addresses inside the current tag/index window, so that hits,
   // clean misses and dirty evictions all occur; the rest land beyond memory.
   function automatic logic [31:0] pick_address();
      logic [31:0] a;
      if ($urandom_range(0, 11) == 0) begin
         a = $urandom();
         if (a < MEMORY_BYTES)
            a[16] = 1'b1;
      end else begin
         a = ((tag_base + $urandom_range(0, tag_span - 1)) % TAG_COUNT) * CACHE_BYTES
           + ((index_base + $urandom_range(0, index_span - 1)) % NUM_LINES) * BLOCK_BYTES
           + $urandom_range(0, BLOCK_BYTES - 1);
      end
      return a;
   endfunction

   // Send one item. Valid stays high after acceptance so that a back-to-back item
   // never lowers and raises it in the same step; hold_requests drops it.
   task automatic issue_access(input logic op, input logic [31:0] addr,
                               input logic [31:0] wdata);
      int unsigned gap;
      if (bursts_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_address    <= addr;
      req_write_data <= wdata;
      do @(posedge clock); while (!req_ready);
      access_outcomes.push_back(apply_access(op, addr, wdata));
   endtask

   task automatic hold_requests();
      req_valid <= 1'b0;
   endtask

   task automatic random_accesses(input int count);
      repeat (count)
         issue_access($urandom_range(0, 1) == 1 ? OP_WRITE : OP_READ, pick_address(),
                      $urandom());
   endtask

   // Stop issuing, wait for every outstanding response, then let the pipeline go quiet.
   // Anything still outstanding after the limit counts as a failure.
   task automatic settle_cache();
      int waited;
      access_outcome_type left;
      waited = 0;
      hold_requests();
      while (access_outcomes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      while (access_outcomes.size() != 0) begin
         left = access_outcomes.pop_front();
         $display("%0t: no response arrived, expected read_data=%h hit=%b wrote_back=%b "
                  , $time, left.read_data, left.hit, left.wrote_back,
                  "address_error=%b total_time=%h", left.address_error, left.total_time);
         mismatches++;
      end
      repeat (4) @(posedge clock);
   endtask

   // Write all four latency registers back to back; only called with the cache idle.
   task automatic set_latencies(input logic [LAT_W-1:0] mem_rd, input logic [LAT_W-1:0] mem_wr,
                                input logic [LAT_W-1:0] cache_rd,
                                input logic [LAT_W-1:0] cache_wr);
      logic [CSR_IDX_W-1:0] regs [4];
      logic [LAT_W-1:0]     vals [4];
      regs = '{CSR_MEM_RD_LAT, CSR_MEM_WR_LAT, CSR_CACHE_RD_LAT, CSR_CACHE_WR_LAT};
      vals = '{mem_rd, mem_wr, cache_rd, cache_wr};
      for (int i = 0; i < 4; i++) begin
         csr_valid      <= 1'b1;
         csr_index      <= regs[i];
         csr_write_data <= vals[i];
         do @(posedge clock); while (!csr_ready);
         case (regs[i])
            CSR_MEM_RD_LAT:   lat.mem_rd   = vals[i];
            CSR_MEM_WR_LAT:   lat.mem_wr   = vals[i];
            CSR_CACHE_RD_LAT: lat.cache_rd = vals[i];
            CSR_CACHE_WR_LAT: lat.cache_wr = vals[i];
            default:          ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h, got %h", $time, field, want, got);
         mismatches++;
      end
   endtask

   // Response side: stall in random bursts while bursts are on.
   int unsigned stall_left = 0;
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 16);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare every accepted response with the oldest outstanding prediction.
   always @(posedge clock) begin : check_responses
      access_outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (access_outcomes.size() == 0) begin
            $display("%0t: unrequested response, expected none, got read_data=%h hit=%b ",
                     $time, rsp_read_data, rsp_hit,
                     "wrote_back=%b address_error=%b total_time=%h",
                     rsp_wrote_back, rsp_address_error, rsp_total_time);
            mismatches++;
         end else begin
            want = access_outcomes.pop_front();
            compare_field("read_data", want.read_data, rsp_read_data);
            compare_field("hit", 32'(want.hit), 32'(rsp_hit));
            compare_field("wrote_back", 32'(want.wrote_back), 32'(rsp_wrote_back));
            compare_field("address_error", 32'(want.address_error), 32'(rsp_address_error));
            compare_field("total_time", want.total_time, rsp_total_time);
         end
      end
   end

   // Reset latencies: miss, hit, unaligned words, dirty eviction and refill,
   // the last in-range word, out-of-range reads and writes.
   task automatic test_reset_latencies();
      issue_access(OP_READ,  32'h0000_0000, 32'hDEAD_BEEF);   // cold miss, data ignored
      issue_access(OP_WRITE, 32'h0000_0004, 32'hFFFF_FFFF);   // hit, line goes dirty
      issue_access(OP_READ,  32'h0000_0007, 32'h0000_0000);   // unaligned, upper word
      issue_access(OP_READ,  32'h0000_0001, 32'hFFFF_FFFF);   // unaligned, lower word
      issue_access(OP_WRITE, 32'h0000_0800, 32'hA5A5_A5A5);   // same line, evict dirty
      issue_access(OP_READ,  32'h0000_0004, 32'h0000_0000);   // evict again, refill
      issue_access(OP_READ,  32'h0000_0802, 32'h0000_0000);   // clean victim, refill
      issue_access(OP_WRITE, 32'h0000_FFFC, 32'h0000_0001);   // last word in range
      issue_access(OP_READ,  32'h0000_FFFF, 32'h0000_0000);   // last byte in range
      issue_access(OP_READ,  32'h0001_0000, 32'h0000_0000);   // first byte beyond memory
      issue_access(OP_WRITE, 32'hFFFF_FFFF, 32'h1234_5678);   // write beyond memory
      issue_access(OP_READ,  32'h8000_0000, 32'h0000_0000);
      issue_access(OP_WRITE, 32'h0000_07FC, 32'h0000_0000);   // evicts the top block
      issue_access(OP_READ,  32'h0000_FFF8, 32'h0000_0000);   // evicts line again
      issue_access(OP_READ,  32'h0000_FFFC, 32'h0000_0000);
      issue_access(OP_WRITE, 32'h0000_0003, 32'h5555_AAAA);   // unaligned write
      issue_access(OP_READ,  32'h0000_0000, 32'h0000_0000);
      issue_access(OP_WRITE, 32'h0000_FFFF, 32'hFFFF_FFFF);   // unaligned, top word
      issue_access(OP_READ,  32'h0000_7FF8, 32'h0000_0000);   // lower half of that line
      issue_access(OP_READ,  32'h0000_FFFE, 32'h0000_0000);
      settle_cache();
   endtask

   // Latencies at both ends of their range.
   task automatic test_latency_extremes();
      tag_base   = 0;
      tag_span   = 4;
      index_base = 0;
      index_span = 8;
      set_latencies('0, '0, '0, '0);
      random_accesses(100);
      settle_cache();
      tag_base = 28;
      set_latencies(LAT_MAX, LAT_MAX, LAT_MAX, LAT_MAX);
      random_accesses(100);
      settle_cache();
   endtask

   // Random latencies and address windows, with and without idle bursts.
   task automatic test_random_traffic();
      for (int phase = 0; phase < 4; phase++) begin
         bursts_on  = (phase != 2);
         tag_base   = $urandom_range(0, TAG_COUNT - 1);
         tag_span   = (phase == 3) ? TAG_COUNT : $urandom_range(2, 6);
         index_base = $urandom_range(0, NUM_LINES - 1);
         index_span = (phase == 3) ? NUM_LINES : $urandom_range(1, 16);
         if (phase == 1)
            set_latencies(LAT_MAX, '0, LAT_MAX, '0);
         else
            set_latencies(LAT_W'($urandom()), LAT_W'($urandom()), LAT_W'($urandom()),
                          LAT_W'($urandom()));
         random_accesses(200);
         settle_cache();
      end
   endtask

   // Closing stretch: no idling on either side.
   task automatic test_streaming();
      bursts_on  = 1'b0;
      tag_base   = $urandom_range(0, TAG_COUNT - 1);
      tag_span   = 3;
      index_base = $urandom_range(0, NUM_LINES - 1);
      index_span = 32;
      set_latencies(LAT_W'($urandom()), LAT_W'($urandom()), LAT_W'($urandom()),
                    LAT_W'($urandom()));
      random_accesses(150);
      settle_cache();
   endtask

   initial begin
      // reset is held first; after release the clearing pass keeps req_ready low
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_latencies();
      test_latency_extremes();
      test_random_traffic();
      test_streaming();
      if (mismatches == 0)
         $display("direct_mapped_write_back_cache_top: match");
      else
         $display("direct_mapped_write_back_cache_top: mismatch");
      $finish;
   end

endmodule
